/* rtl/core/pfx_pkg.sv */
package pfx_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int Q_FRAC      = 16;
    localparam int NUM_W       = 16;
    localparam int DEPTH_W     = 5;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int DIVD_W      = DATA_W + Q_FRAC;
    localparam int CNT_W       = $clog2(DIVD_W + 1);
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 40;

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_OPER = 2'd1,
        ACT_FIN  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        STAT_OK    = 3'd0,
        STAT_UNDER = 3'd1,
        STAT_OVER  = 3'd2,
        STAT_DIVZ  = 3'd3,
        STAT_SAT   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_TOP,
        S_RD_NXT,
        S_CAPT,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load_in;
        logic rd_top;
        logic rd_nxt;
        logic cap_rhs;
        logic cap_lhs;
        logic mul_go;
        logic div_start;
        logic finish;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_action action;
        t_op     op;
        logic    sp_zero;
        logic    sp_lt2;
        logic    rhs_zero;
        logic    div_done;
        logic    out_free;
    } t_sts;

endpackage

/* rtl/core/postfix_expression_stack_evaluator_top.sv */
// reverse polish evaluator on a 16-entry stack of signed q16.16 values
// input channel s_axis: one token per word, tuser holds the action
// (push number, apply operator, finish), tdata holds the literal and the
// operator code; output channel m_axis: exactly one result word per token
// with status, top of stack and depth in tdata and the final-answer flag in
// tuser
// the block takes one token at a time: s_axis_tready is high only while it
// waits for a token; a token reads the top two stack entries from the stack
// ram one per cycle (registered read port), then executes
// and responds: from accept it passes the read-top, read-next, capture,
// execute and respond states before m_axis_tvalid; a valid multiply also
// passes S_MUL for its registered 32x32 product, and a valid divide waits
// in S_DIV on the restoring divider, which retires one of 48 quotient bits
// a cycle; s_axis_tready returns in the cycle after the result is loaded
// reset empties the stack and drops any pending result; stack contents are
// not cleared, no clearing pass is needed
// while m_axis_tready is low the finished result waits in the output
// register; the next token still runs but holds its result until that word
// is taken, and no further token is accepted meanwhile
module postfix_expression_stack_evaluator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // number[15:0], operator_code[17:16], zero pad
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // status[2:0], top_value[34:3], depth[39:35]
    output logic        m_axis_tuser    // final_res
);

    import pfx_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    pfx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pfx_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("token accepted while one is in progress");

    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:35] <= 5'(STACK_DEPTH))
        else $error("reported depth beyond stack size");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("result loaded over a pending word");

    a_final_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[2:0] == STAT_OK && m_axis_tdata[39:35] == '0)
        else $error("final answer with nonempty stack or bad status");

endmodule

/* rtl/core/pfx_ram.sv */
module pfx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/pfx_div.sv */
module pfx_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pfx_pkg::DIVD_W-1:0]  i_dividend,
    input  logic [pfx_pkg::DATA_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [pfx_pkg::DIVD_W-1:0]  o_quotient
);

    import pfx_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [DATA_W-1:0] r_div;

    logic [DATA_W:0]   w_shift;
    logic [DATA_W:0]   w_diff;
    logic              w_ge;

    // one quotient bit per cycle, restoring
    assign w_shift = {r_rem, r_quo[DIVD_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_div};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DATA_W-1:0] : w_shift[DATA_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/core/pfx_ctrl.sv */
module pfx_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pfx_pkg::t_sts  i_sts,
    output pfx_pkg::t_cmd  o_cmd
);

    import pfx_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_oper_ok;

    assign w_oper_ok = (i_sts.action == ACT_OPER) && !i_sts.sp_lt2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_RD_TOP;
                end
            end
            S_RD_TOP: n_state = S_RD_NXT;
            S_RD_NXT: n_state = S_CAPT;
            S_CAPT:   n_state = S_EXEC;
            S_EXEC: begin
                if (w_oper_ok && i_sts.op == OP_MUL) begin
                    n_state = S_MUL;
                end else if (w_oper_ok && i_sts.op == OP_DIV && !i_sts.rhs_zero) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_MUL: n_state = S_RESP;
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_RD_TOP: o_cmd.rd_top = 1'b1;
            S_RD_NXT: begin
                o_cmd.rd_nxt  = 1'b1;
                o_cmd.cap_rhs = 1'b1;
            end
            S_CAPT: o_cmd.cap_lhs = 1'b1;
            S_EXEC: begin
                if (w_oper_ok && i_sts.op == OP_MUL) begin
                    o_cmd.mul_go = 1'b1;
                end else if (w_oper_ok && i_sts.op == OP_DIV && !i_sts.rhs_zero) begin
                    o_cmd.div_start = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                end
            end
            S_MUL: o_cmd.finish = 1'b1;
            S_DIV: o_cmd.finish = i_sts.div_done;
            S_RESP: o_cmd.out_load = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

/* rtl/core/pfx_dp.sv */
module pfx_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pfx_pkg::t_cmd                  i_cmd,
    output pfx_pkg::t_sts                  o_sts,
    input  logic [pfx_pkg::IN_DATA_W-1:0]  i_in_data,
    input  logic [1:0]                     i_in_user,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [pfx_pkg::OUT_DATA_W-1:0] o_out_data,
    output logic                           o_out_user
);

    import pfx_pkg::*;

    localparam logic [DIVD_W-1:0] DIV_NEG_LIM = DIVD_W'(1) << (DATA_W - 1);
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    t_action                    r_action;
    logic signed [NUM_W-1:0]    r_number;
    t_op                        r_op;
    logic [SP_W-1:0]            r_sp;
    logic signed [DATA_W-1:0]   r_rhs;
    logic signed [DATA_W-1:0]   r_lhs;
    logic signed [2*DATA_W-1:0] r_prod;
    logic                       r_neg;
    t_status                    r_status;
    logic signed [DATA_W-1:0]   r_top;
    logic                       r_fin;
    logic                       r_out_valid;
    logic [OUT_DATA_W-1:0]      r_out_data;
    logic                       r_out_user;

    logic [SP_W-1:0]            w_sp_m1;
    logic [SP_W-1:0]            w_sp_m2;
    logic                       w_sp_full;
    logic [DATA_W-1:0]          w_rdata;
    logic [DATA_W-1:0]          w_lhs_mag;
    logic [DATA_W-1:0]          w_rhs_mag;
    logic                       w_div_done;
    logic [DIVD_W-1:0]          w_quo;
    logic signed [DATA_W:0]     w_sum;
    logic signed [2*DATA_W-1:0] w_prod_adj;
    logic signed [2*DATA_W-1:0] w_mul_q;
    logic [DATA_W:0]            w_mul_hi;
    logic signed [DATA_W-1:0]   w_push_val;
    logic signed [DATA_W-1:0]   w_op_val;
    logic                       w_op_sat;
    logic                       w_we;
    logic [ADDR_W-1:0]          w_waddr;
    logic [DATA_W-1:0]          w_wdata;
    logic [SP_W-1:0]            w_new_sp;
    t_status                    w_new_status;
    logic signed [DATA_W-1:0]   w_new_top;
    logic                       w_new_fin;

    assign w_sp_m1   = r_sp - SP_W'(1);
    assign w_sp_m2   = r_sp - SP_W'(2);
    assign w_sp_full = r_sp == SP_W'(STACK_DEPTH);

    pfx_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we & i_cmd.finish),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_top | i_cmd.rd_nxt),
        .i_raddr (i_cmd.rd_top ? w_sp_m1[ADDR_W-1:0] : w_sp_m2[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_lhs_mag = r_lhs[DATA_W-1] ? DATA_W'(-r_lhs) : DATA_W'(r_lhs);
    assign w_rhs_mag = r_rhs[DATA_W-1] ? DATA_W'(-r_rhs) : DATA_W'(r_rhs);

    pfx_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({w_lhs_mag, {Q_FRAC{1'b0}}}),
        .i_divisor  (w_rhs_mag),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // product scaled back by 2^16, truncated toward zero
    assign w_prod_adj = r_prod + (r_prod[2*DATA_W-1] ? (2*DATA_W)'((1 << Q_FRAC) - 1) : '0);
    assign w_mul_q    = w_prod_adj >>> Q_FRAC;
    assign w_mul_hi   = w_mul_q[2*DATA_W-1:DATA_W-1];
    assign w_push_val = {r_number, {Q_FRAC{1'b0}}};

    always_comb begin
        w_sum    = '0;
        w_op_val = '0;
        w_op_sat = 1'b0;
        case (r_op)
            OP_ADD, OP_SUB: begin
                if (r_op == OP_ADD) begin
                    w_sum = {r_lhs[DATA_W-1], r_lhs} + {r_rhs[DATA_W-1], r_rhs};
                end else begin
                    w_sum = {r_lhs[DATA_W-1], r_lhs} - {r_rhs[DATA_W-1], r_rhs};
                end
                w_op_sat = w_sum[DATA_W] != w_sum[DATA_W-1];
                w_op_val = w_op_sat ? (w_sum[DATA_W] ? VAL_MIN : VAL_MAX) : w_sum[DATA_W-1:0];
            end
            OP_MUL: begin
                w_op_sat = !((&w_mul_hi) || !(|w_mul_hi));
                w_op_val = w_op_sat ? (w_mul_q[2*DATA_W-1] ? VAL_MIN : VAL_MAX)
                                    : w_mul_q[DATA_W-1:0];
            end
            OP_DIV: begin
                if (r_neg) begin
                    w_op_sat = w_quo > DIV_NEG_LIM;
                    w_op_val = w_op_sat ? VAL_MIN : DATA_W'(-w_quo[DATA_W-1:0]);
                end else begin
                    w_op_sat = |w_quo[DIVD_W-1:DATA_W-1];
                    w_op_val = w_op_sat ? VAL_MAX : w_quo[DATA_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // push writes the literal, operators write the combined value
    always_comb begin
        w_we         = 1'b0;
        w_waddr      = w_sp_m2[ADDR_W-1:0];
        w_wdata      = w_op_val;
        w_new_sp     = r_sp;
        w_new_status = STAT_OK;
        w_new_top    = (r_sp == '0) ? '0 : r_rhs;
        w_new_fin    = 1'b0;
        case (r_action)
            ACT_PUSH: begin
                if (w_sp_full) begin
                    w_new_status = STAT_OVER;
                end else begin
                    w_we      = 1'b1;
                    w_waddr   = r_sp[ADDR_W-1:0];
                    w_wdata   = w_push_val;
                    w_new_sp  = r_sp + SP_W'(1);
                    w_new_top = w_push_val;
                end
            end
            ACT_OPER: begin
                if (r_sp < SP_W'(2)) begin
                    w_new_status = STAT_UNDER;
                end else if (r_op == OP_DIV && r_rhs == '0) begin
                    w_new_status = STAT_DIVZ;
                end else begin
                    w_we         = 1'b1;
                    w_new_sp     = w_sp_m1;
                    w_new_top    = w_op_val;
                    w_new_status = w_op_sat ? STAT_SAT : STAT_OK;
                end
            end
            ACT_FIN: begin
                if (r_sp == '0) begin
                    w_new_status = STAT_UNDER;
                end else begin
                    w_new_sp  = '0;
                    w_new_fin = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_sp <= w_new_sp;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_action <= t_action'(i_in_user);
            r_number <= i_in_data[NUM_W-1:0];
            r_op     <= t_op'(i_in_data[NUM_W+1:NUM_W]);
        end
        if (i_cmd.cap_rhs) begin
            r_rhs <= w_rdata;
        end
        if (i_cmd.cap_lhs) begin
            r_lhs <= w_rdata;
        end
        if (i_cmd.mul_go) begin
            r_prod <= r_lhs * r_rhs;
        end
        if (i_cmd.div_start) begin
            r_neg <= r_lhs[DATA_W-1] ^ r_rhs[DATA_W-1];
        end
        if (i_cmd.finish) begin
            r_status <= w_new_status;
            r_top    <= w_new_top;
            r_fin    <= w_new_fin;
        end
        if (i_cmd.out_load) begin
            r_out_data <= {DEPTH_W'(r_sp), r_top, r_status};
            r_out_user <= r_fin;
        end
    end

    always_comb begin
        o_sts.action   = r_action;
        o_sts.op       = r_op;
        o_sts.sp_zero  = r_sp == '0;
        o_sts.sp_lt2   = r_sp < SP_W'(2);
        o_sts.rhs_zero = r_rhs == '0;
        o_sts.div_done = w_div_done;
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

endmodule

/* test/postfix_expression_stack_evaluator_top_tb.sv */
`timescale 1ns / 1ps

module postfix_expression_stack_evaluator_top_tb;
    import pfx_pkg::*;

    localparam logic [1:0] ACT_BAD   = 2'd3;
    localparam longint     Q_ONE     = 64'sd1 <<< Q_FRAC;
    localparam longint     INT_HI    = 64'sd2147483647;
    localparam longint     INT_LO    = -64'sd2147483648;
    localparam int         N_TOKENS  = 1500;
    localparam int         IDLE_MAX  = 1000;
    localparam int         DRAIN_CYC = 80;

    typedef struct {
        logic [1:0]  act;
        logic [15:0] num;
        logic [1:0]  op;
    } t_token;

    typedef struct {
        t_status            status;
        logic signed [31:0] top;
        logic [4:0]         depth;
        logic               fin;
    } t_stack_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // number[15:0], operator_code[17:16], zero pad
    logic [1:0]  s_axis_tuser;   // action[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // status[2:0], top_value[34:3], depth[39:35]
    logic        m_axis_tuser;   // final_res

    postfix_expression_stack_evaluator_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    t_token             token_q[$];
    t_stack_result      result_q[$];
    logic signed [31:0] stk [STACK_DEPTH];
    int                 sp = 0;
    int                 n_tokens = 0;
    int                 errors = 0;
    int                 tok_sent_cnt = 0;
    int                 tok_acc_cnt = 0;
    int                 res_cnt = 0;
    int                 res_seen = 0;
    int                 idle_cycles = 0;
    int                 in_wait = 0;
    int                 out_wait = 0;
    bit                 in_calm = 0;
    bit                 out_calm = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic note_mismatch(input string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    task automatic add_token(input logic [1:0] act, input logic [15:0] num,
                             input logic [1:0] op);
        t_token t;
        t.act = act;
        t.num = num;
        t.op  = op;
        token_q.push_back(t);
        if (act != ACT_BAD)
            n_tokens++;
    endtask

    function automatic logic [15:0] pick_number();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 8)) - 16'd4;
            2: begin
                case ($urandom_range(0, 3))
                    0: return 16'h7fff;
                    1: return 16'h8000;
                    2: return 16'h0001;
                    default: return 16'hffff;
                endcase
            end
            default: return 16'($urandom_range(0, 300));
        endcase
    endfunction

    // well-formed expression ending in finish
    task automatic gen_expression(input int n_ops);
        int depth;
        int ops;
        depth = 0;
        ops = 0;
        while (ops < n_ops) begin
            if (depth < 2 || (depth < 15 && $urandom_range(0, 2) == 0)) begin
                add_token(ACT_PUSH, pick_number(), 2'($urandom));
                depth++;
            end else begin
                add_token(ACT_OPER, 16'($urandom), 2'($urandom));
                depth--;
                ops++;
            end
        end
        add_token(ACT_FIN, 16'($urandom), 2'($urandom));
    endtask

    function automatic void eval_token(input logic [1:0] act, input logic [15:0] num,
                                       input logic [1:0] op);
        t_stack_result r;
        longint        lhs;
        longint        rhs;
        longint        acc;
        r.status = STAT_OK;
        r.fin = 1'b0;
        r.top = 32'sd0;
        case (act)
            ACT_PUSH: begin
                if (sp >= STACK_DEPTH) begin
                    r.status = STAT_OVER;
                end else begin
                    stk[sp] = {num, 16'h0000};
                    sp++;
                end
            end
            ACT_OPER: begin
                if (sp < 2) begin
                    r.status = STAT_UNDER;
                end else begin
                    rhs = stk[sp - 1];
                    lhs = stk[sp - 2];
                    acc = 0;
                    case (op)
                        OP_ADD: acc = lhs + rhs;
                        OP_SUB: acc = lhs - rhs;
                        OP_MUL: acc = (lhs * rhs) / Q_ONE;
                        default: begin
                            if (rhs == 0)
                                r.status = STAT_DIVZ;
                            else
                                acc = (lhs * Q_ONE) / rhs;
                        end
                    endcase
                    if (r.status != STAT_DIVZ) begin
                        if (acc > INT_HI) begin
                            acc = INT_HI;
                            r.status = STAT_SAT;
                        end else if (acc < INT_LO) begin
                            acc = INT_LO;
                            r.status = STAT_SAT;
                        end
                        sp--;
                        stk[sp - 1] = acc[31:0];
                    end
                end
            end
            ACT_FIN: begin
                if (sp == 0) begin
                    r.status = STAT_UNDER;
                end else begin
                    r.top = stk[sp - 1];
                    sp = 0;
                    r.fin = 1'b1;
                end
            end
            default: ;
        endcase
        if (!r.fin && sp > 0)
            r.top = stk[sp - 1];
        r.depth = sp[4:0];
        result_q.push_back(r);
    endfunction

    // token driver
    always @(negedge i_clk) begin
        t_token t;
        if (i_rst_n && !(s_axis_tvalid && tok_acc_cnt != tok_sent_cnt)) begin
            if (in_wait > 0) begin
                s_axis_tvalid <= 1'b0;
                in_wait--;
            end else if (token_q.size() != 0) begin
                t = token_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {6'b0, t.op, t.num};
                s_axis_tuser  <= t.act;
                tok_sent_cnt++;
                if ($urandom_range(0, 39) == 0)
                    in_calm = !in_calm;
                in_wait = in_calm ? 0 : $urandom_range(0, 10);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result backpressure
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (res_cnt != res_seen) begin
                res_seen = res_cnt;
                if ($urandom_range(0, 39) == 0)
                    out_calm = !out_calm;
                out_wait = out_calm ? 0 : $urandom_range(0, 10);
            end
            if (out_wait > 0) begin
                m_axis_tready <= 1'b0;
                out_wait--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_stack_result e;
        bit            moved;
        if (i_rst_n) begin
            moved = 0;
            if (s_axis_tvalid && s_axis_tready) begin
                eval_token(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[17:16]);
                tok_acc_cnt++;
                moved = 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (result_q.size() == 0) begin
                    note_mismatch($sformatf("word %0d arrived with nothing expected", res_cnt));
                end else begin
                    e = result_q.pop_front();
                    if (m_axis_tdata[2:0] !== e.status)
                        note_mismatch($sformatf("word %0d status %0d, expected %0d",
                                                res_cnt, m_axis_tdata[2:0], e.status));
                    if (m_axis_tdata[34:3] !== e.top)
                        note_mismatch($sformatf("word %0d top %h, expected %h",
                                                res_cnt, m_axis_tdata[34:3], e.top));
                    if (m_axis_tdata[39:35] !== e.depth)
                        note_mismatch($sformatf("word %0d depth %0d, expected %0d",
                                                res_cnt, m_axis_tdata[39:35], e.depth));
                    if (m_axis_tuser !== e.fin)
                        note_mismatch($sformatf("word %0d final %b, expected %b",
                                                res_cnt, m_axis_tuser, e.fin));
                end
                res_cnt++;
                moved = 1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_MAX) begin
                $display("timeout: no handshake for %0d cycles", IDLE_MAX);
                $display("FAIL postfix_expression_stack_evaluator_top");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;

        // empty-stack cases
        add_token(ACT_FIN, 16'h0000, OP_ADD);
        add_token(ACT_OPER, 16'h0000, OP_ADD);
        add_token(ACT_BAD, 16'hffff, OP_DIV);
        add_token(ACT_PUSH, 16'h7fff, OP_ADD);
        add_token(ACT_OPER, 16'h0000, OP_SUB);
        add_token(ACT_PUSH, 16'h8000, OP_ADD);
        add_token(ACT_OPER, 16'h0000, OP_ADD);
        // divide by zero keeps the stack
        add_token(ACT_PUSH, 16'h0000, OP_ADD);
        add_token(ACT_OPER, 16'h0000, OP_DIV);
        add_token(ACT_OPER, 16'h0000, OP_MUL);
        // saturation on multiply and subtract
        add_token(ACT_PUSH, 16'h7fff, OP_ADD);
        add_token(ACT_PUSH, 16'h7fff, OP_ADD);
        add_token(ACT_OPER, 16'h0000, OP_MUL);
        add_token(ACT_PUSH, 16'h8000, OP_ADD);
        add_token(ACT_OPER, 16'h0000, OP_SUB);
        add_token(ACT_PUSH, 16'h0003, OP_ADD);
        add_token(ACT_OPER, 16'h0000, OP_DIV);
        add_token(ACT_BAD, 16'h0000, OP_ADD);
        add_token(ACT_FIN, 16'hffff, OP_DIV);
        // divide by a fraction saturates low
        add_token(ACT_PUSH, 16'h8000, OP_ADD);
        add_token(ACT_PUSH, 16'h0001, OP_ADD);
        add_token(ACT_PUSH, 16'h0002, OP_ADD);
        add_token(ACT_OPER, 16'h0000, OP_DIV);
        add_token(ACT_OPER, 16'h0000, OP_DIV);
        add_token(ACT_FIN, 16'h0000, OP_ADD);

        while (n_tokens < N_TOKENS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: gen_expression($urandom_range(1, 8));
                6: begin
                    // fill near or past full
                    repeat ($urandom_range(14, 18))
                        add_token(ACT_PUSH, pick_number(), 2'($urandom));
                    repeat ($urandom_range(0, 4))
                        add_token(ACT_OPER, 16'($urandom), 2'($urandom));
                    add_token(ACT_FIN, 16'($urandom), 2'($urandom));
                end
                7: begin
                    repeat ($urandom_range(1, 6))
                        add_token(2'($urandom), 16'($urandom), 2'($urandom));
                end
                8: begin
                    repeat ($urandom_range(0, 2))
                        add_token(ACT_PUSH, pick_number(), 2'($urandom));
                    repeat ($urandom_range(1, 4))
                        add_token(ACT_OPER, 16'($urandom), 2'($urandom));
                end
                default: add_token(ACT_FIN, 16'($urandom), 2'($urandom));
            endcase
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (token_q.size() != 0 || tok_acc_cnt != tok_sent_cnt || result_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (result_q.size() != 0)
            note_mismatch($sformatf("%0d words never arrived", result_q.size()));

        if (errors == 0) begin
            $display("PASS postfix_expression_stack_evaluator_top");
        end else begin
            $display("FAIL postfix_expression_stack_evaluator_top");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/pfx_pkg.sv
rtl/core/pfx_ram.sv
rtl/core/pfx_div.sv
rtl/core/pfx_ctrl.sv
rtl/core/pfx_dp.sv
rtl/core/postfix_expression_stack_evaluator_top.sv
test/postfix_expression_stack_evaluator_top_tb.sv
